>>> rtl/core/euler_to_quaternion_core_macros.svh
// ----------------------------------------------------------------------------
// Euler to quaternion assertion macros
// Shared concurrent assertion forms for the core, clocked on clk_i and
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef EULER_TO_QUATERNION_CORE_MACROS_SVH
`define EULER_TO_QUATERNION_CORE_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define EUQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define EUQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/euq_pkg.sv
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Shared lane types, CORDIC constants and the arctangent table.
// ----------------------------------------------------------------------------
package euq_pkg;

  // Internal CORDIC datapath width (Q30 with headroom).
  localparam int unsigned CW = 34;
  // Width of a sine or cosine value in Q30.
  localparam int unsigned SW = 32;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned NUM_AXES = 3;

  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] CORDIC_K    = 34'sd652032874;

  // One rotation in flight: vector, residual angle and the half-turn flag.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
  } lane_t;

  // Contents of one cell of the chain.
  typedef struct packed {
    logic                       vld;
    lane_t [NUM_AXES-1:0]       lane;
  } cell_t;

  // Arctangent of 2^-step in Q30, truncated.
  function automatic logic signed [CW-1:0] atan_q30(input int unsigned step);
    logic signed [CW-1:0] r;
    case (step)
      0:  r = 34'sd843314856;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043836;
      3:  r = 34'sd133525158;
      4:  r = 34'sd67021686;
      5:  r = 34'sd33543515;
      6:  r = 34'sd16775850;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194282;
      9:  r = 34'sd2097149;
      10: r = 34'sd1048575;
      11: r = 34'sd524287;
      12: r = 34'sd262143;
      13: r = 34'sd131071;
      14: r = 34'sd65535;
      15: r = 34'sd32767;
      16: r = 34'sd16383;
      17: r = 34'sd8191;
      18: r = 34'sd4095;
      19: r = 34'sd2047;
      20: r = 34'sd1023;
      21: r = 34'sd511;
      22: r = 34'sd255;
      23: r = 34'sd127;
      24: r = 34'sd63;
      25: r = 34'sd31;
      26: r = 34'sd15;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/euq_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation for all three axes, registered.
// ----------------------------------------------------------------------------
module euq_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  euq_pkg::cell_t cell_i,
  output euq_pkg::cell_t cell_o
);

  localparam logic signed [euq_pkg::CW-1:0] ATAN = euq_pkg::atan_q30(STEP);

  euq_pkg::cell_t cell_d, cell_q;

  // Rotate each vector toward the residual angle.
  always_comb begin
    logic signed [euq_pkg::CW-1:0] xs, ys;
    cell_d = cell_i;
    for (int a = 0; a < euq_pkg::NUM_AXES; a++) begin
      xs = cell_i.lane[a].x >>> STEP;
      ys = cell_i.lane[a].y >>> STEP;
      if (!cell_i.lane[a].z[euq_pkg::CW-1]) begin
        cell_d.lane[a].x = cell_i.lane[a].x - ys;
        cell_d.lane[a].y = cell_i.lane[a].y + xs;
        cell_d.lane[a].z = cell_i.lane[a].z - ATAN;
      end else begin
        cell_d.lane[a].x = cell_i.lane[a].x + ys;
        cell_d.lane[a].y = cell_i.lane[a].y - xs;
        cell_d.lane[a].z = cell_i.lane[a].z + ATAN;
      end
    end
  end

  // The whole cell is cleared at reset and advances with the enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> rtl/core/euq_combine.sv
// ----------------------------------------------------------------------------
// Quaternion product pipeline
// Forms the pairwise products, rounds them, multiplies by the third factor
// and sums the terms of each quaternion component.
// ----------------------------------------------------------------------------
module euq_combine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic signed [euq_pkg::SW-1:0]     sn_i [euq_pkg::NUM_AXES],
  input  logic signed [euq_pkg::SW-1:0]     cs_i [euq_pkg::NUM_AXES],
  output logic                              vld_o,
  output logic signed [2*euq_pkg::SW:0]     sum_o [4]
);

  localparam int unsigned SW = euq_pkg::SW;
  localparam int unsigned PW = 2 * SW;

  logic [2:0] vld_q;

  // Stage A: products cx*cy, sx*sy, sx*cy, cx*sy.
  logic signed [PW-1:0] pa_q [4];
  logic signed [SW-1:0] sza_q, cza_q;
  // Stage B: products rounded back to Q30.
  logic signed [SW-1:0] rb_q [4];
  logic signed [SW-1:0] szb_q, czb_q;
  // Stage C: the eight Q60 terms.
  logic signed [PW-1:0] tc_q [8];
  // Stage D: component sums.
  logic signed [PW:0]   sd_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // Datapath registers advance with the pipeline enable.
  always_ff @(posedge clk_i) begin
    logic signed [PW-1:0] rnd;
    if (en_i) begin
      pa_q[0] <= cs_i[0] * cs_i[1];
      pa_q[1] <= sn_i[0] * sn_i[1];
      pa_q[2] <= sn_i[0] * cs_i[1];
      pa_q[3] <= cs_i[0] * sn_i[1];
      sza_q   <= sn_i[2];
      cza_q   <= cs_i[2];

      for (int k = 0; k < 4; k++) begin
        rnd      = pa_q[k] + (PW'(1) <<< 29);
        rb_q[k] <= SW'(rnd >>> 30);
      end
      szb_q <= sza_q;
      czb_q <= cza_q;

      tc_q[0] <= rb_q[0] * czb_q;
      tc_q[1] <= rb_q[1] * szb_q;
      tc_q[2] <= rb_q[2] * czb_q;
      tc_q[3] <= rb_q[3] * szb_q;
      tc_q[4] <= rb_q[3] * czb_q;
      tc_q[5] <= rb_q[2] * szb_q;
      tc_q[6] <= rb_q[0] * szb_q;
      tc_q[7] <= rb_q[1] * czb_q;

      sd_q[0] <= (PW+1)'(tc_q[0]) - (PW+1)'(tc_q[1]);
      sd_q[1] <= (PW+1)'(tc_q[2]) + (PW+1)'(tc_q[3]);
      sd_q[2] <= (PW+1)'(tc_q[4]) - (PW+1)'(tc_q[5]);
      sd_q[3] <= (PW+1)'(tc_q[6]) + (PW+1)'(tc_q[7]);
    end
  end

  // The sums are valid one stage after the terms.
  logic vld_d_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_d_q <= vld_q[2];
    end
  end

  assign vld_o = vld_d_q;
  assign sum_o = sd_q;

endmodule

>>> rtl/core/euler_to_quaternion_core.sv
// ----------------------------------------------------------------------------
// Euler angles to quaternion core
// Converts an XYZ roll, pitch, yaw triple into a saturated unit quaternion.
// ----------------------------------------------------------------------------
// The core accepts one angle triple per clock cycle while the output side does not
// stall and delivers one quaternion per triple, in order. The pipeline is a chain
// of 30 CORDIC cells (one micro-rotation each), plus one input folding stage, one
// sign stage, four product, rounding and sum stages and the output register. When
// the output side holds tready low, the whole pipeline freezes and s_axis_tready
// drops.
module euler_to_quaternion_core #(
  parameter int unsigned ANGLE_WIDTH = 16,
  parameter int unsigned QUAT_WIDTH  = 16,
  localparam int unsigned IN_W  = ((3 * ANGLE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((4 * QUAT_WIDTH + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // Fields from bit 0 up: angle_x, angle_y, angle_z.
  input  logic [IN_W-1:0]     s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // Fields from bit 0 up: quat_w, quat_x, quat_y, quat_z.
  output logic [OUT_W-1:0]    m_axis_tdata
);

  localparam int unsigned CW    = euq_pkg::CW;
  localparam int unsigned SW    = euq_pkg::SW;
  localparam int unsigned NSTEP = euq_pkg::CORDIC_STEPS;
  localparam int unsigned NAX   = euq_pkg::NUM_AXES;
  localparam int unsigned SHIFT = 62 - QUAT_WIDTH;
  localparam int unsigned RW    = 2 * SW + 2;

  logic en;
  logic out_vld_q;

  // The pipeline moves whenever the output register can take a result.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Fold each half angle into the range of plus or minus pi/2.
  euq_pkg::cell_t fold_d, fold_q;

  always_comb begin
    logic signed [CW-1:0] z;
    fold_d     = '0;
    fold_d.vld = s_axis_tvalid;
    for (int a = 0; a < NAX; a++) begin
      z = CW'($signed(s_axis_tdata[a*ANGLE_WIDTH +: ANGLE_WIDTH])) <<< (32 - ANGLE_WIDTH);
      fold_d.lane[a].x    = euq_pkg::CORDIC_K;
      fold_d.lane[a].y    = '0;
      fold_d.lane[a].flip = 1'b0;
      if (z > euq_pkg::HALF_PI_Q30) begin
        fold_d.lane[a].z    = z - euq_pkg::PI_Q30;
        fold_d.lane[a].flip = 1'b1;
      end else if (z < -euq_pkg::HALF_PI_Q30) begin
        fold_d.lane[a].z    = z + euq_pkg::PI_Q30;
        fold_d.lane[a].flip = 1'b1;
      end else begin
        fold_d.lane[a].z = z;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= '0;
    end else if (en) begin
      fold_q <= fold_d;
    end
  end

  // Chain of CORDIC cells, one micro-rotation per cell.
  euq_pkg::cell_t chain [NSTEP+1];
  assign chain[0] = fold_q;

  for (genvar i = 0; i < NSTEP; i++) begin : g_cell
    euq_cordic_cell #(
      .STEP (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // Undo the half-turn fold and narrow to sine and cosine.
  logic                 sc_vld_q;
  logic signed [SW-1:0] sn_q [NAX];
  logic signed [SW-1:0] cs_q [NAX];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_vld_q <= 1'b0;
    end else if (en) begin
      sc_vld_q <= chain[NSTEP].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < NAX; a++) begin
        if (chain[NSTEP].lane[a].flip) begin
          sn_q[a] <= SW'(-chain[NSTEP].lane[a].y);
          cs_q[a] <= SW'(-chain[NSTEP].lane[a].x);
        end else begin
          sn_q[a] <= SW'(chain[NSTEP].lane[a].y);
          cs_q[a] <= SW'(chain[NSTEP].lane[a].x);
        end
      end
    end
  end

  // Products and sums of the quaternion components.
  logic                   sum_vld;
  logic signed [2*SW:0]   sum [4];

  euq_combine u_combine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sc_vld_q),
    .sn_i   (sn_q),
    .cs_i   (cs_q),
    .vld_o  (sum_vld),
    .sum_o  (sum)
  );

  // Round, saturate and register the result.
  logic signed [QUAT_WIDTH-1:0] quat_q [4];
  localparam logic signed [RW-1:0] ONE_R  = RW'(1) <<< (QUAT_WIDTH - 2);
  localparam logic signed [RW-1:0] HALF_R = RW'(1) <<< (SHIFT - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sum_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [RW-1:0] r;
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        r = (RW'(sum[k]) + HALF_R) >>> SHIFT;
        if (r > ONE_R) begin
          quat_q[k] <= QUAT_WIDTH'(ONE_R);
        end else if (r < -ONE_R) begin
          quat_q[k] <= QUAT_WIDTH'(-ONE_R);
        end else begin
          quat_q[k] <= QUAT_WIDTH'(r);
        end
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < 4; k++) begin
      m_axis_tdata[k*QUAT_WIDTH +: QUAT_WIDTH] = quat_q[k];
    end
  end

  // All four components lie within plus or minus one.
  logic quat_in_range;

  always_comb begin
    quat_in_range = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if ((quat_q[k] > QUAT_WIDTH'(ONE_R)) || (quat_q[k] < -QUAT_WIDTH'(ONE_R))) begin
        quat_in_range = 1'b0;
      end
    end
  end

  // Checks on the result range, on the output valid source and on holding the result while stalled.
`include "euler_to_quaternion_core_macros.svh"

  `EUQ_ASSERT_IMP(a_quat_range, m_axis_tvalid, quat_in_range, "quaternion component beyond unit range")
  `EUQ_ASSERT_NEXT(a_out_from_sum, en && sum_vld, m_axis_tvalid, "result lost between sum stage and output")
  `EUQ_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Euler to quaternion core testbench
// Streams angle triples through the core with random gaps on the input side
// and random stalls on the output side, and checks every quaternion against
// a fixed-point CORDIC predictor kept inside this module.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW = 16;
  localparam int QW = 16;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint PI_VAL  = 64'sd3373259426;
  localparam longint K_START = 64'sd652032874;
  localparam int LATENCY = 37;

  typedef struct packed {
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] w;
  } quat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [3*AW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [4*QW-1:0] m_axis_tdata;

  quat_t quat_expected_q[$];
  int unsigned mismatches = 0;
  int unsigned quats_checked = 0;
  int unsigned triples_sent = 0;
  bit calm_mode = 1'b0;

  always #2 clk_i = ~clk_i;

  euler_to_quaternion_core #(.ANGLE_WIDTH(AW), .QUAT_WIDTH(QW)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // Sine and cosine of half the angle, Q30, by a 30-step CORDIC.
  function automatic void half_sin_cos(input logic signed [AW-1:0] ang,
                                       output longint sn, output longint cs);
    longint z, x, y, xs, ys;
    bit flip;
    longint atan_tab [30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                              33543515, 16775850, 8388437, 4194282, 2097149,
                              1048575, 524287, 262143, 131071, 65535,
                              32767, 16383, 8191, 4095, 2047,
                              1023, 511, 255, 127, 63, 31, 15, 8, 4, 2};
    z = longint'(ang) <<< (32 - AW);
    x = K_START;
    y = 0;
    flip = 1'b0;
    if (z > HALF_PI) begin
      z -= PI_VAL;
      flip = 1'b1;
    end else if (z < -HALF_PI) begin
      z += PI_VAL;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys;
        y += xs;
        z -= atan_tab[i];
      end else begin
        x += ys;
        y -= xs;
        z += atan_tab[i];
      end
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  // First product rounded to Q30, then times the third factor in Q60.
  function automatic longint product3(input longint a, input longint b, input longint c);
    longint ab;
    ab = (a * b + (64'sd1 <<< 29)) >>> 30;
    return ab * c;
  endfunction

  // Round the Q60 sum to the output format and clip to plus or minus one.
  function automatic logic signed [QW-1:0] round_clip(input longint sum);
    longint r;
    longint one;
    one = 64'sd1 <<< (QW - 2);
    r = (sum + (64'sd1 <<< (60 - (QW - 2) - 1))) >>> (60 - (QW - 2));
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[QW-1:0];
  endfunction

  function automatic quat_t predict_quat(input logic [3*AW-1:0] angles);
    longint sx, cx, sy, cy, sz, cz;
    quat_t q;
    half_sin_cos(angles[AW-1:0], sx, cx);
    half_sin_cos(angles[2*AW-1:AW], sy, cy);
    half_sin_cos(angles[3*AW-1:2*AW], sz, cz);
    q.w = round_clip(product3(cx, cy, cz) - product3(sx, sy, sz));
    q.x = round_clip(product3(sx, cy, cz) + product3(cx, sy, sz));
    q.y = round_clip(product3(cx, sy, cz) - product3(sx, cy, sz));
    q.z = round_clip(product3(cx, cy, sz) + product3(sx, sy, cz));
    return q;
  endfunction

  function automatic int draw_gap();
    if (calm_mode || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Send one angle triple; called at a rising edge, returns at its transfer edge.
  task automatic send_angles(input logic signed [AW-1:0] ax, input logic signed [AW-1:0] ay,
                             input logic signed [AW-1:0] az);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {az, ay, ax};
    do @(posedge clk_i); while (!s_axis_tready);
    quat_expected_q.push_back(predict_quat({az, ay, ax}));
    triples_sent++;
  endtask

  // Receive side: random stalls, each transfer checked against the oldest prediction.
  initial begin
    int stall;
    quat_t got, want;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata;
      if (quat_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected quaternion transfer %h", got);
      end else begin
        want = quat_expected_q.pop_front();
        quats_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
                     want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
        end
      end
    end
  end

  // Field extremes, zero, the half-pi fold boundary and angles beyond pi.
  task automatic test_directed();
    logic signed [AW-1:0] vals [10] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd25735,
                                        -16'sd25735, 16'sh7FFF, 16'sh8000, 16'sd1,
                                        -16'sd1, 16'sd12868};
    foreach (vals[i]) send_angles(vals[i], vals[(i + 3) % 10], vals[(i + 7) % 10]);
    send_angles(16'sd25736, 16'sd25736, 16'sd25736);
    send_angles(16'sh8000, 16'sh8000, 16'sh8000);
    send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
  endtask

  // Mostly in-range triples, some with any bit pattern.
  task automatic test_random();
    logic signed [AW-1:0] a [3];
    for (int n = 0; n < 1500; n++) begin
      if (n % 100 == 0) calm_mode = ($urandom_range(0, 3) == 0);
      foreach (a[k]) begin
        if ($urandom_range(0, 3) == 0) a[k] = AW'($urandom());
        else a[k] = AW'($signed($urandom_range(0, 51472)) - 25736);
      end
      send_angles(a[0], a[1], a[2]);
    end
    calm_mode = 1'b0;
  endtask

  initial begin
    int waited;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (quat_expected_q.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2 * LATENCY) @(posedge clk_i);
    $display("Sent %0d angle triples, checked %0d quaternions, %0d mismatches.",
             triples_sent, quats_checked, mismatches);
    if (mismatches == 0 && quat_expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
